FILE: rtl/lcgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgs_pkg
// shared constants and types of the lidar column ground segmenter
// ----------------------------------------------------------------------------
package lcgs_pkg;

  localparam int ROWS   = 64;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(ROWS + 1);

  localparam int ROW_W   = 6;
  localparam int TBL_W   = 16;
  localparam int RANGE_W = 18;
  localparam int Z_W     = 16;
  localparam int TAG_W   = 20;
  localparam int SUM_W   = TBL_W + ROW_W;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  localparam logic [TBL_W-1:0] THR_RESET = 16'd300;

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row_lo;
    logic [ROW_W-1:0] row_hi;
  } sum_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } sum_rsp_t;

endpackage

FILE: rtl/lcgs_radius_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgs_radius_sum
// radius increment table and serial accumulator over a row gap
// ----------------------------------------------------------------------------
module lcgs_radius_sum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tbl_we_i,
  input  logic [lcgs_pkg::ROW_AW-1:0]  tbl_addr_i,
  input  logic [lcgs_pkg::TBL_W-1:0]   tbl_wdata_i,
  input  lcgs_pkg::sum_req_t           req_i,
  output lcgs_pkg::sum_rsp_t           rsp_o
);

  logic [lcgs_pkg::TBL_W-1:0] mem_q [lcgs_pkg::ROWS];
  logic [lcgs_pkg::TBL_W-1:0] rdata_q;
  logic                       rd_en;
  logic                       busy_q, busy_d;
  logic                       pend_q, pend_d;
  logic                       pend_ok_q, pend_ok_d;
  logic                       done_q, done_d;
  logic [lcgs_pkg::ROW_W-1:0] ti_q, ti_d;
  logic [lcgs_pkg::ROW_W-1:0] hi_q, hi_d;
  logic [lcgs_pkg::SUM_W-1:0] acc_q, acc_d;

  always_comb begin
    busy_d    = busy_q;
    pend_d    = pend_q;
    pend_ok_d = pend_ok_q;
    done_d    = 1'b0;
    ti_d      = ti_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    rd_en     = 1'b0;
    if (req_i.start) begin
      busy_d    = 1'b1;
      ti_d      = req_i.row_lo;
      hi_d      = req_i.row_hi;
      acc_d     = '0;
      pend_d    = 1'b0;
      pend_ok_d = 1'b0;
    end else if (busy_q) begin
      if (pend_q && pend_ok_q) begin
        acc_d = acc_q + lcgs_pkg::SUM_W'(rdata_q);
      end
      if (ti_q < hi_q) begin
        rd_en     = 1'b1;
        pend_d    = 1'b1;
        pend_ok_d = (32'(ti_q) < lcgs_pkg::ROWS);
        ti_d      = ti_q + lcgs_pkg::ROW_W'(1);
      end else begin
        pend_d = 1'b0;
        if (!pend_q) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      pend_ok_q <= 1'b0;
      done_q    <= 1'b0;
      ti_q      <= '0;
      hi_q      <= '0;
      acc_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      pend_q    <= pend_d;
      pend_ok_q <= pend_ok_d;
      done_q    <= done_d;
      ti_q      <= ti_d;
      hi_q      <= hi_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      mem_q[tbl_addr_i] <= tbl_wdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[lcgs_pkg::ROW_AW'(ti_q)];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sum  = acc_q;

endmodule

FILE: rtl/lidar_column_ground_segmenter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_column_ground_segmenter_core
// splits one lidar column into segments and labels each ground or non-ground
// ----------------------------------------------------------------------------
// usage
//   s_axis carries loads (tuser 0: table entry at row) and points (tuser 1),
//   points of a column in rising row order, tlast on the last point of the
//   column. m_axis returns the tag of every point of a closed segment with
//   its label in tuser, tlast on the final result caused by one input.
//   cfg_we_i writes the height spread threshold; the user does so only while
//   the block is idle, which the block itself does not enforce.
// sequence
//   a load is taken in idle, and so is a point that starts a column. a later
//   point of the column first sums the radius table entries from the previous
//   row up to its own row, exclusive, one entry a cycle. a segment that closes
//   first latches its label, then each tag goes through tag memory read, output
//   load and the output transaction, which waits for the receiver. one item
//   is in work at a time.
// reset
//   segment state is cleared and the threshold returns to 300 mm; the table
//   is undefined until loaded. a stalled receiver holds the block, the
//   result stays in the output register and no input is taken meanwhile.
// ----------------------------------------------------------------------------
module lidar_column_ground_segmenter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcgs_pkg::TBL_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row, table_value_mm, range_mm, height_mm, point_tag, zero pad
  input  logic [lcgs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_tag_res, zero pad
  output logic [lcgs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // is_ground
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SUM     = 3'd1;
  localparam logic [2:0] ST_CLOSE   = 3'd2;
  localparam logic [2:0] ST_FL_RD   = 3'd3;
  localparam logic [2:0] ST_FL_LD   = 3'd4;
  localparam logic [2:0] ST_FL_WAIT = 3'd5;

  logic [2:0] state_q, state_d;

  logic [lcgs_pkg::ROW_W-1:0]   in_row;
  logic [lcgs_pkg::TBL_W-1:0]   in_tbl;
  logic [lcgs_pkg::RANGE_W-1:0] in_range;
  logic signed [lcgs_pkg::Z_W-1:0] in_z;
  logic [lcgs_pkg::TAG_W-1:0]   in_tag;

  logic [lcgs_pkg::TBL_W-1:0]   thr_q, thr_d;
  logic [lcgs_pkg::CNT_W-1:0]   count_q, count_d;
  logic [lcgs_pkg::CNT_W-1:0]   k_q, k_d;
  logic [lcgs_pkg::ROW_W-1:0]   prev_row_q, prev_row_d;
  logic [lcgs_pkg::RANGE_W-1:0] prev_range_q, prev_range_d;
  logic signed [lcgs_pkg::Z_W-1:0] hmax_q, hmax_d, hmin_q, hmin_d;
  logic [lcgs_pkg::ROW_W-1:0]   row_q, row_d;
  logic [lcgs_pkg::RANGE_W-1:0] range_q, range_d;
  logic signed [lcgs_pkg::Z_W-1:0] z_q, z_d;
  logic [lcgs_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic                         end_q, end_d;
  logic                         mode_q, mode_d;
  logic                         ground_q, ground_d;

  logic                         out_valid_q, out_valid_d;
  logic [lcgs_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  logic                         out_ground_q, out_ground_d;
  logic                         out_last_q, out_last_d;

  logic [lcgs_pkg::TAG_W-1:0]   tag_mem_q [lcgs_pkg::ROWS];
  logic [lcgs_pkg::TAG_W-1:0]   tag_rdata_q;
  logic                         tag_we, tag_re;
  logic [lcgs_pkg::ROW_AW-1:0]  tag_waddr;
  logic [lcgs_pkg::TAG_W-1:0]   tag_wdata;

  logic                         tbl_we;
  lcgs_pkg::sum_req_t           sum_req;
  lcgs_pkg::sum_rsp_t           sum_rsp;

  logic signed [lcgs_pkg::Z_W:0] spread;
  logic                         ground_now;
  logic [lcgs_pkg::RANGE_W-1:0] diff;
  logic                         last_tag;

  assign in_row   = s_axis_tdata[5:0];
  assign in_tbl   = s_axis_tdata[21:6];
  assign in_range = s_axis_tdata[39:22];
  assign in_z     = s_axis_tdata[55:40];
  assign in_tag   = s_axis_tdata[75:56];

  assign spread     = {hmax_q[lcgs_pkg::Z_W-1], hmax_q} - {hmin_q[lcgs_pkg::Z_W-1], hmin_q};
  assign ground_now = !((count_q > lcgs_pkg::CNT_W'(1)) &&
                        (spread > $signed({1'b0, thr_q})));
  assign diff       = (range_q >= prev_range_q) ? (range_q - prev_range_q)
                                                : (prev_range_q - range_q);
  assign last_tag   = (k_q == (count_q - lcgs_pkg::CNT_W'(1)));

  assign s_axis_tready = (state_q == ST_IDLE);

  lcgs_radius_sum u_radius_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tbl_we_i    (tbl_we),
    .tbl_addr_i  (lcgs_pkg::ROW_AW'(in_row)),
    .tbl_wdata_i (in_tbl),
    .req_i       (sum_req),
    .rsp_o       (sum_rsp)
  );

  always_comb begin
    state_d      = state_q;
    thr_d        = thr_q;
    count_d      = count_q;
    k_d          = k_q;
    prev_row_d   = prev_row_q;
    prev_range_d = prev_range_q;
    hmax_d       = hmax_q;
    hmin_d       = hmin_q;
    row_d        = row_q;
    range_d      = range_q;
    z_d          = z_q;
    tag_d        = tag_q;
    end_d        = end_q;
    mode_d       = mode_q;
    ground_d     = ground_q;
    out_valid_d  = out_valid_q;
    out_tag_d    = out_tag_q;
    out_ground_d = out_ground_q;
    out_last_d   = out_last_q;
    tag_we       = 1'b0;
    tag_re       = 1'b0;
    tag_waddr    = '0;
    tag_wdata    = tag_q;
    tbl_we       = 1'b0;
    sum_req      = '0;

    if (cfg_we_i) begin
      thr_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == lcgs_pkg::REQ_LOAD) begin
            tbl_we = (32'(in_row) < lcgs_pkg::ROWS);
          end else begin
            row_d   = in_row;
            range_d = in_range;
            z_d     = in_z;
            tag_d   = in_tag;
            end_d   = s_axis_tlast;
            mode_d  = 1'b1;
            if (count_q == '0) begin
              tag_we       = 1'b1;
              tag_wdata    = in_tag;
              count_d      = lcgs_pkg::CNT_W'(1);
              prev_row_d   = in_row;
              prev_range_d = in_range;
              hmax_d       = in_z;
              hmin_d       = in_z;
              if (s_axis_tlast) begin
                state_d = ST_CLOSE;
              end
            end else if (32'(count_q) < lcgs_pkg::ROWS) begin
              sum_req.start  = 1'b1;
              sum_req.row_lo = prev_row_q;
              sum_req.row_hi = in_row;
              state_d        = ST_SUM;
            end else if (s_axis_tlast) begin
              state_d = ST_CLOSE;
            end
          end
        end
      end
      ST_SUM: begin
        if (sum_rsp.done) begin
          if ({{(lcgs_pkg::SUM_W - lcgs_pkg::RANGE_W){1'b0}}, diff} < sum_rsp.sum) begin
            tag_we       = 1'b1;
            tag_waddr    = lcgs_pkg::ROW_AW'(count_q);
            count_d      = count_q + lcgs_pkg::CNT_W'(1);
            prev_row_d   = row_q;
            prev_range_d = range_q;
            if (z_q > hmax_q) begin
              hmax_d = z_q;
            end
            if (z_q < hmin_q) begin
              hmin_d = z_q;
            end
            state_d = end_q ? ST_CLOSE : ST_IDLE;
          end else begin
            mode_d  = 1'b0;
            state_d = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        ground_d = ground_now;
        k_d      = '0;
        state_d  = ST_FL_RD;
      end
      ST_FL_RD: begin
        tag_re  = 1'b1;
        state_d = ST_FL_LD;
      end
      ST_FL_LD: begin
        out_valid_d  = 1'b1;
        out_tag_d    = tag_rdata_q;
        out_ground_d = ground_q;
        out_last_d   = last_tag && (mode_q || !end_q);
        state_d      = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (last_tag) begin
            if (mode_q) begin
              count_d = '0;
              state_d = ST_IDLE;
            end else begin
              tag_we       = 1'b1;
              count_d      = lcgs_pkg::CNT_W'(1);
              prev_row_d   = row_q;
              prev_range_d = range_q;
              hmax_d       = z_q;
              hmin_d       = z_q;
              mode_d       = 1'b1;
              state_d      = end_q ? ST_CLOSE : ST_IDLE;
            end
          end else begin
            k_d     = k_q + lcgs_pkg::CNT_W'(1);
            state_d = ST_FL_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= lcgs_pkg::THR_RESET;
      count_q      <= '0;
      k_q          <= '0;
      prev_row_q   <= '0;
      prev_range_q <= '0;
      hmax_q       <= '0;
      hmin_q       <= '0;
      mode_q       <= 1'b0;
      ground_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      end_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      thr_q        <= thr_d;
      count_q      <= count_d;
      k_q          <= k_d;
      prev_row_q   <= prev_row_d;
      prev_range_q <= prev_range_d;
      hmax_q       <= hmax_d;
      hmin_q       <= hmin_d;
      mode_q       <= mode_d;
      ground_q     <= ground_d;
      out_valid_q  <= out_valid_d;
      end_q        <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    range_q      <= range_d;
    z_q          <= z_d;
    tag_q        <= tag_d;
    out_tag_q    <= out_tag_d;
    out_ground_q <= out_ground_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem_q[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rdata_q <= tag_mem_q[lcgs_pkg::ROW_AW'(k_q)];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lcgs_pkg::OUT_TDATA_W - lcgs_pkg::TAG_W){1'b0}}, out_tag_q};
  assign m_axis_tuser  = out_ground_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/lcgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgs_checker
// port level checks of the ground segmenter, bound to the top level
// ----------------------------------------------------------------------------
module lcgs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lcgs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);

  // input side is closed while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // after a table load the input side is ready again in the next cycle
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == lcgs_pkg::REQ_LOAD)
    |=> s_axis_tready)
    else $error("not ready after a table load");

  // final result of an input frees the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after the final result");

endmodule

bind lidar_column_ground_segmenter_core lcgs_checker u_lcgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lidar column ground segmenter: a short table of
// hand-written transactions, then random columns, noise and table reloads under
// four height spread limits, with bursty input, a stalling receiver and one
// long receiver hold-off; every labelled tag is checked against a predictor
// ----------------------------------------------------------------------------
module tb;

  localparam int ROWS        = lcgs_pkg::ROWS;
  localparam int ROW_W       = lcgs_pkg::ROW_W;
  localparam int TBL_W       = lcgs_pkg::TBL_W;
  localparam int RANGE_W     = lcgs_pkg::RANGE_W;
  localparam int Z_W         = lcgs_pkg::Z_W;
  localparam int TAG_W       = lcgs_pkg::TAG_W;
  localparam int IN_TDATA_W  = lcgs_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lcgs_pkg::OUT_TDATA_W;
  localparam logic REQ_LOAD  = lcgs_pkg::REQ_LOAD;
  localparam logic REQ_POINT = lcgs_pkg::REQ_POINT;
  localparam logic [TBL_W-1:0] THR_RESET = lcgs_pkg::THR_RESET;

  localparam int PAD_W        = IN_TDATA_W - ROW_W - TBL_W - RANGE_W - Z_W - TAG_W;
  localparam int RANGE_MAX    = (1 << RANGE_W) - 1;
  localparam int QUIET_CYCLES = 320;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int PHASE_ITEMS  = 97;
  localparam int DIR_N        = 19;
  localparam int SHOWN_ERRORS = 10;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic [TAG_W-1:0]   tag;
    logic [Z_W-1:0]     z;
    logic [RANGE_W-1:0] range_mm;
    logic [TBL_W-1:0]   tval;
    logic [ROW_W-1:0]   row;
  } lidar_word_t;

  typedef struct packed {
    logic        req;
    logic        eoc;
    lidar_word_t w;
  } lidar_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             ground;
    logic             last;
  } label_t;

  typedef struct packed {
    logic               req;
    logic [ROW_W-1:0]   row;
    logic [TBL_W-1:0]   tval;
    logic [RANGE_W-1:0] range_mm;
    logic [Z_W-1:0]     z;
    logic [TAG_W-1:0]   tag;
    logic               eoc;
    logic               typed;
    logic [TAG_W-1:0]   etag;
    logic               egnd;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [TBL_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // predictor state
  logic [TBL_W-1:0]   tbl_mm [ROWS];
  logic [TAG_W-1:0]   open_tags [ROWS];
  int                 open_count;
  logic [ROW_W-1:0]   last_row;
  logic [RANGE_W-1:0] last_range;
  int                 z_hi;
  int                 z_lo;
  logic [TBL_W-1:0]   spread_limit_mm;

  label_t expected_labels[$];
  int     errors;
  int     results_seen;
  int     burst_left;
  int     loads_sent;
  int     points_sent;
  int     full_columns;
  dir_row_t dir_tab [DIR_N];

  lidar_column_ground_segmenter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic void append_label(input label_t l);
    expected_labels.insert(expected_labels.size(), l);
  endfunction

  function automatic int sum_budget(int from_row, int to_row);
    int s;
    s = 0;
    for (int r = from_row; r < to_row; r++) begin
      if (r < ROWS) s += int'(tbl_mm[r]);
    end
    return s;
  endfunction

  function automatic void start_segment(lidar_word_t w);
    open_tags[0] = w.tag;
    open_count   = 1;
    last_row     = w.row;
    last_range   = w.range_mm;
    z_hi         = $signed(w.z);
    z_lo         = $signed(w.z);
  endfunction

  function automatic void flush_segment();
    logic   gnd;
    label_t l;
    gnd = !(open_count > 1 && (z_hi - z_lo) > int'(spread_limit_mm));
    for (int k = 0; k < open_count; k++) begin
      l.tag    = open_tags[k];
      l.ground = gnd;
      l.last   = 1'b0;
      append_label(l);
    end
    open_count = 0;
  endfunction

  function automatic int classify_item(lidar_item_t it);
    int     queued;
    int     thr;
    int     diff;
    int     zi;
    label_t tail;
    queued = expected_labels.size();
    if (it.req == REQ_LOAD) begin
      tbl_mm[it.w.row] = it.w.tval;
      return 0;
    end
    zi = $signed(it.w.z);
    if (open_count == 0) begin
      start_segment(it.w);
    end else if (open_count < ROWS) begin
      thr  = sum_budget(int'(last_row), int'(it.w.row));
      diff = int'(it.w.range_mm) - int'(last_range);
      if (diff < 0) diff = -diff;
      if (diff < thr) begin
        open_tags[open_count] = it.w.tag;
        open_count++;
        if (zi > z_hi) z_hi = zi;
        if (zi < z_lo) z_lo = zi;
        last_row   = it.w.row;
        last_range = it.w.range_mm;
      end else begin
        flush_segment();
        start_segment(it.w);
      end
    end
    if (it.eoc && open_count > 0) flush_segment();
    if (expected_labels.size() > queued) begin
      tail      = expected_labels.pop_back();
      tail.last = 1'b1;
      append_label(tail);
    end
    return expected_labels.size() - queued;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [TBL_W-1:0] pick_table_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return TBL_W'($urandom_range(50, 3000));
      default: return TBL_W'($urandom);
    endcase
  endfunction

  // a range that joins the open segment when asked and the budget allows
  function automatic int pick_range(int at_row, bit want_join);
    int thr;
    int lim;
    int cand;
    thr = (open_count > 0) ? sum_budget(int'(last_row), at_row) : 0;
    if (!want_join || thr == 0) return int'($urandom_range(0, RANGE_MAX));
    lim  = (thr - 1 < 1500) ? thr - 1 : 1500;
    cand = int'($urandom_range(0, lim));
    if ($urandom_range(0, 1) == 1) cand = -cand;
    cand += int'(last_range);
    if (cand < 0 || cand > RANGE_MAX) cand = 2 * int'(last_range) - cand;
    return cand;
  endfunction

  function automatic logic [Z_W-1:0] pick_height(int base, int band);
    int z;
    z = base + int'($urandom_range(0, band)) - band / 2;
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return Z_W'(z);
  endfunction

  function automatic int pick_band();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 250;
      2: return 700;
      default: return 65535;
    endcase
  endfunction

  function automatic lidar_item_t make_point(int row, int rmm, logic [Z_W-1:0] z, bit eoc);
    lidar_item_t it;
    it            = '0;
    it.req        = REQ_POINT;
    it.eoc        = eoc;
    it.w.row      = ROW_W'(row);
    it.w.tval     = TBL_W'($urandom);
    it.w.range_mm = RANGE_W'(rmm);
    it.w.z        = z;
    it.w.tag      = TAG_W'($urandom);
    return it;
  endfunction

  function automatic lidar_item_t make_load(int row, logic [TBL_W-1:0] value);
    lidar_item_t it;
    it          = '0;
    it.req      = REQ_LOAD;
    it.eoc      = $urandom_range(0, 1) == 1;
    it.w        = lidar_word_t'({$urandom, $urandom, 16'($urandom)});
    it.w.pad    = '0;
    it.w.row    = ROW_W'(row);
    it.w.tval   = value;
    return it;
  endfunction

  task automatic send_item(input lidar_item_t it, output int produced);
    int gap;
    if (burst_left == 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.w;
    s_axis_tuser  <= it.req;
    s_axis_tlast  <= it.eoc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    produced = classify_item(it);
    if (it.req == REQ_LOAD) loads_sent++;
    else points_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_for_quiet();
    while (expected_labels.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_spread_limit(input logic [TBL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    spread_limit_mm = value;
  endtask

  task automatic send_column();
    int rows_q[$];
    int npts;
    int r;
    int zb;
    int band;
    int n;
    lidar_item_t it;
    npts = $urandom_range(1, 12);
    r    = $urandom_range(0, 10);
    for (int k = 0; k < npts && r < ROWS; k++) begin
      rows_q.push_front(r);
      r += ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, 4));
    end
    zb   = int'($urandom_range(0, 40000)) - 20000;
    band = pick_band();
    for (int k = rows_q.size() - 1; k >= 0; k--) begin
      it = make_point(rows_q[k], pick_range(rows_q[k], $urandom_range(0, 99) < 85),
                      pick_height(zb, band), k == 0);
      send_item(it, n);
    end
  endtask

  // 64 joining rows, then one more point that overflows and ends the column
  task automatic send_full_column();
    int zb;
    int band;
    int n;
    lidar_item_t it;
    for (int r = 0; r < ROWS - 1; r++) begin
      if (tbl_mm[r] == '0) begin
        send_item(make_load(r, TBL_W'($urandom_range(1, 65535))), n);
      end
    end
    zb   = int'($urandom_range(0, 20000)) - 10000;
    band = pick_band();
    for (int r = 0; r < ROWS; r++) begin
      it = make_point(r, pick_range(r, r != 0), pick_height(zb, band), 1'b0);
      send_item(it, n);
    end
    it = make_point($urandom_range(0, ROWS - 1), $urandom_range(0, RANGE_MAX),
                    pick_height(zb, band), 1'b1);
    send_item(it, n);
    full_columns++;
  endtask

  task automatic send_noise();
    int n;
    lidar_item_t it;
    it     = make_point($urandom_range(0, ROWS - 1), $urandom_range(0, RANGE_MAX),
                        Z_W'($urandom), $urandom_range(0, 3) == 0);
    send_item(it, n);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    rx_mode_e mode;
    int       len;
    bit       held_off;
    held_off      = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          RX_FREE:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= $urandom_range(0, 1) == 1;
          RX_SPARSE: m_axis_tready <= $urandom_range(0, 3) == 0;
          default:   m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    label_t exp_l;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_labels.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS) begin
          $display("mismatch: unexpected result tdata %06h tuser %0d tlast %0d",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end else begin
        exp_l = expected_labels.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(exp_l.tag) || m_axis_tuser !== exp_l.ground ||
            m_axis_tlast !== exp_l.last) begin
          errors++;
          if (errors <= SHOWN_ERRORS) begin
            $display({"mismatch: expected tag %05h ground %0d last %0d, ",
                      "got tdata %06h tuser %0d tlast %0d"},
                     exp_l.tag, exp_l.ground, exp_l.last, m_axis_tdata, m_axis_tuser,
                     m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- main
  initial begin
    logic [TBL_W-1:0] limits [4];
    lidar_item_t it;
    label_t typed_l;
    int n;
    int phase_start;
    int pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    errors        = 0;
    results_seen  = 0;
    burst_left    = 0;
    loads_sent    = 0;
    points_sent   = 0;
    full_columns  = 0;
    open_count    = 0;
    last_row      = '0;
    last_range    = '0;
    z_hi          = 0;
    z_lo          = 0;
    spread_limit_mm = THR_RESET;
    foreach (tbl_mm[r]) tbl_mm[r] = '0;

    // req, row, table value, range, height, tag, column end, typed, tag, ground
    dir_tab = '{
      '{REQ_LOAD,  6'd0,  16'd100,   18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd1,  16'd100,   18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd2,  16'hFFFF,  18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd3,  16'd0,     18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd4,  16'd200,   18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd5,  16'd200,   18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd62, 16'd10,    18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_LOAD,  6'd63, 16'd0,     18'd0,      16'h0000, 20'h00000, 1'b0, 1'b0, 20'h0, 1'b0},
      // lone points at the field extremes are ground
      '{REQ_POINT, 6'd0,  16'd0,     18'd0,      16'h8000, 20'h00000, 1'b1, 1'b1, 20'h00000, 1'b1},
      '{REQ_POINT, 6'd0,  16'hFFFF,  18'h3FFFF,  16'h7FFF, 20'hFFFFF, 1'b1, 1'b1, 20'hFFFFF, 1'b1},
      '{REQ_POINT, 6'd0,  16'd0,     18'd1000,   16'd0,    20'h00001, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_POINT, 6'd1,  16'd0,     18'd1050,   16'd400,  20'h00002, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_POINT, 6'd2,  16'd0,     18'd1100,   16'd0,    20'h00003, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_POINT, 6'd3,  16'd0,     18'd60000,  16'h8000, 20'h00004, 1'b0, 1'b0, 20'h0, 1'b0},
      // zero budget breaks the segment
      '{REQ_POINT, 6'd4,  16'd0,     18'd60000,  16'd100,  20'h00005, 1'b0, 1'b0, 20'h0, 1'b0},
      // same row again never joins
      '{REQ_POINT, 6'd4,  16'd0,     18'd60000,  16'd0,    20'h00006, 1'b0, 1'b1, 20'h00005, 1'b1},
      // spread equal to the limit stays ground
      '{REQ_POINT, 6'd6,  16'd0,     18'd60399,  16'd300,  20'h00007, 1'b1, 1'b0, 20'h0, 1'b0},
      '{REQ_POINT, 6'd62, 16'd0,     18'd5,      16'd0,    20'h00008, 1'b0, 1'b0, 20'h0, 1'b0},
      '{REQ_POINT, 6'd63, 16'd0,     18'd14,     16'd301,  20'h00009, 1'b1, 1'b0, 20'h0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      it            = '0;
      it.req        = dir_tab[i].req;
      it.eoc        = dir_tab[i].eoc;
      it.w.row      = dir_tab[i].row;
      it.w.tval     = dir_tab[i].tval;
      it.w.range_mm = dir_tab[i].range_mm;
      it.w.z        = dir_tab[i].z;
      it.w.tag      = dir_tab[i].tag;
      send_item(it, n);
      if (dir_tab[i].typed) begin
        repeat (n) void'(expected_labels.pop_back());
        typed_l.tag    = dir_tab[i].etag;
        typed_l.ground = dir_tab[i].egnd;
        typed_l.last   = 1'b1;
        append_label(typed_l);
      end
    end

    limits = '{16'd0, 16'hFFFF, TBL_W'($urandom_range(100, 2000)), THR_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      idle_sender();
      wait_for_quiet();
      write_spread_limit(limits[ph]);
      phase_start = loads_sent + points_sent;
      if (ph == 0) begin
        for (int r = 0; r < ROWS; r++) send_item(make_load(r, pick_table_value()), n);
      end
      if (ph >= 2) send_full_column();
      while (loads_sent + points_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) send_column();
        else if (pick < 9) send_noise();
        else send_item(make_load($urandom_range(0, ROWS - 1), pick_table_value()), n);
      end
    end

    idle_sender();
    wait_for_quiet();
    $display("covered %0d table loads and %0d points, %0d full-column overflows,",
             loads_sent, points_sent, full_columns);
    $display("four spread limits from 0 to 65535; %0d labelled tags checked",
             results_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lcgs_pkg.sv
rtl/lcgs_radius_sum.sv
rtl/lidar_column_ground_segmenter_core.sv
rtl/lcgs_checker.sv
bench/tb.sv
